>>> sv/aes256_pkg.sv
// Package for the AES-256 block cipher core: S-box tables, round constants,
// field arithmetic helpers and the sequencer state type. No dependencies.
`default_nettype none

package aes256_pkg;

  localparam int unsigned KeyRegs   = 4;
  localparam int unsigned NumRounds = 14;
  localparam int unsigned NumRows   = NumRounds + 1;
  localparam int unsigned RowW      = $clog2(NumRows);

  typedef enum logic [1:0] {
    CfgKey0 = 2'd0,
    CfgKey1 = 2'd1,
    CfgKey2 = 2'd2,
    CfgKey3 = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    StIdle,
    StExpand,
    StLoad,
    StInit,
    StRound,
    StDone
  } state_e;

  localparam logic [0:255][7:0] FwdBox = {
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [0:255][7:0] RevBox = {
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  localparam logic [0:7][7:0] RoundConst = {
    8'h00, 8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40
  };

  function automatic logic [7:0] xtime(input logic [7:0] a);
    xtime = a[7] ? ({a[6:0], 1'b0} ^ 8'h1b) : {a[6:0], 1'b0};
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    sub_word = {FwdBox[w[31:24]], FwdBox[w[23:16]], FwdBox[w[15:8]], FwdBox[w[7:0]]};
  endfunction

endpackage

`default_nettype wire

>>> sv/aes256_key_exp.sv
// Key schedule for the AES-256 core: expands the 256-bit key one 128-bit row
// per cycle into a fifteen-row round-key memory. Depends on aes256_pkg.
`default_nettype none

module aes256_key_exp (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [255:0]                key_i,
  input  wire logic                        rd_en_i,
  input  wire logic [aes256_pkg::RowW-1:0] rd_row_i,
  output logic [127:0]                     rd_key_o,
  output logic                             done_o
);

  logic [127:0] mem [aes256_pkg::NumRows];
  logic [aes256_pkg::RowW-1:0] row_q, row_d;
  logic busy_q, busy_d;
  logic done_q, done_d;
  logic [127:0] prev1_q, prev2_q, wdata;
  logic [31:0] t, w0, w1, w2, w3;

  always_comb begin
    if (!row_q[0]) begin
      t = aes256_pkg::sub_word({prev1_q[23:0], prev1_q[31:24]}) ^
          {aes256_pkg::RoundConst[row_q[aes256_pkg::RowW-1:1]], 24'h0};
    end else begin
      t = aes256_pkg::sub_word(prev1_q[31:0]);
    end
    w0 = prev2_q[127:96] ^ t;
    w1 = prev2_q[95:64] ^ w0;
    w2 = prev2_q[63:32] ^ w1;
    w3 = prev2_q[31:0] ^ w2;
    if (row_q == aes256_pkg::RowW'(0)) begin
      wdata = key_i[255:128];
    end else if (row_q == aes256_pkg::RowW'(1)) begin
      wdata = key_i[127:0];
    end else begin
      wdata = {w0, w1, w2, w3};
    end
  end

  always_comb begin
    row_d  = row_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      row_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      row_d = row_q + aes256_pkg::RowW'(1);
      if (row_q == aes256_pkg::RowW'(aes256_pkg::NumRows - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      row_q  <= row_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      mem[row_q] <= wdata;
      prev2_q    <= prev1_q;
      prev1_q    <= wdata;
    end
    if (rd_en_i) begin
      rd_key_o <= mem[rd_row_i];
    end
  end

  assign done_o = done_q;

endmodule

`default_nettype wire

>>> sv/aes256_round.sv
// One AES round, forward or inverse, shared by all fourteen rounds of the
// core. Purely combinational. Depends on aes256_pkg.
`default_nettype none

module aes256_round (
  input  wire logic [127:0] state_i,
  input  wire logic [127:0] rkey_i,
  input  wire logic         decrypt_i,
  input  wire logic         last_i,
  output logic [127:0]      state_o
);

  logic [7:0] s   [16];
  logic [7:0] fs  [16];
  logic [7:0] is  [16];
  logic [7:0] fm  [16];
  logic [7:0] im  [16];
  logic [7:0] ia  [16];
  logic [127:0] fwd_sb, fwd_mx, inv_ad, inv_mx;

  always_comb begin
    for (int k = 0; k < 16; k++) begin
      s[k] = state_i[127-8*k -: 8];
    end
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        fs[c*4+r] = aes256_pkg::FwdBox[s[((c + r) & 3)*4 + r]];
        is[c*4+r] = aes256_pkg::RevBox[s[((c - r) & 3)*4 + r]];
      end
    end
    for (int k = 0; k < 16; k++) begin
      fwd_sb[127-8*k -: 8] = fs[k];
    end
    inv_ad = 128'(0);
    for (int k = 0; k < 16; k++) begin
      inv_ad[127-8*k -: 8] = is[k] ^ rkey_i[127-8*k -: 8];
      ia[k] = is[k] ^ rkey_i[127-8*k -: 8];
    end
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        logic [7:0] a0, a1, a2, a3, x2, x4, x8, b, e, d, n;
        fm[c*4+r] = '0;
        im[c*4+r] = '0;
        a0 = fs[c*4 + r];
        a1 = fs[c*4 + ((r + 1) & 3)];
        a2 = fs[c*4 + ((r + 2) & 3)];
        a3 = fs[c*4 + ((r + 3) & 3)];
        fm[c*4+r] = aes256_pkg::xtime(a0) ^ aes256_pkg::xtime(a1) ^ a1 ^ a2 ^ a3;
        for (int j = 0; j < 4; j++) begin
          x2 = aes256_pkg::xtime(ia[c*4 + ((r + j) & 3)]);
          x4 = aes256_pkg::xtime(x2);
          x8 = aes256_pkg::xtime(x4);
          n  = ia[c*4 + ((r + j) & 3)];
          e  = x8 ^ x4 ^ x2;
          b  = x8 ^ x2 ^ n;
          d  = x8 ^ x4 ^ n;
          unique case (j)
            0:       im[c*4+r] = im[c*4+r] ^ e;
            1:       im[c*4+r] = im[c*4+r] ^ b;
            2:       im[c*4+r] = im[c*4+r] ^ d;
            default: im[c*4+r] = im[c*4+r] ^ x8 ^ n;
          endcase
        end
      end
    end
    for (int k = 0; k < 16; k++) begin
      fwd_mx[127-8*k -: 8] = fm[k];
      inv_mx[127-8*k -: 8] = im[k];
    end
    if (decrypt_i) begin
      state_o = last_i ? inv_ad : inv_mx;
    end else begin
      state_o = (last_i ? fwd_sb : fwd_mx) ^ rkey_i;
    end
  end

endmodule

`default_nettype wire

>>> sv/aes256_block_cipher_core.sv
// Top level of the AES-256 ECB core: key registers, round sequencer and
// output register. Depends on aes256_pkg, aes256_key_exp and aes256_round.
//
// Usage. The key is written through the plain write port (cfg_we_i,
// cfg_index_i, cfg_data_i) as four 64-bit words, key byte 0 in the top bits
// of word 0, while the core is idle. Blocks arrive on the request channel
// (in_valid_i/in_ready_o) with func_i low to encrypt and high to decrypt;
// results leave on the output channel (out_valid_o/out_ready_i).
// An accepted request passes through a state fetching the first round
// key, a state for the initial key addition and fourteen round states,
// one per round on the shared round unit, and is then written to the
// output register. The first request after reset or after any key write
// first runs the key schedule, one row of four words per cycle over
// fifteen rows. in_ready_o is high only while the sequencer is idle, so
// no new request is taken before the previous one has left it. A
// finished result waits in the output register; the next request is
// taken meanwhile and only its final write waits for the receiver.
// Reset clears the key to zero and marks it unexpanded; the round-key
// memory needs no clearing since it is always filled before use.
`default_nettype none

module aes256_block_cipher_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [63:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        func_i,
  input  wire logic [63:0] block_high_i,
  input  wire logic [63:0] block_low_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [63:0]      result_high_o,
  output logic [63:0]      result_low_o
);

  aes256_pkg::state_e state_q, state_d;
  logic [63:0] key_q [aes256_pkg::KeyRegs];
  logic expanded_q;
  logic decrypt_q;
  logic [127:0] data_q, round_out, rkey;
  logic [aes256_pkg::RowW-1:0] rnd_q, rnd_next, rd_row;
  logic rd_en, exp_start, exp_done, accept, out_load, out_valid_q;
  logic [127:0] result_q;

  assign accept = in_valid_i && in_ready_o;

  aes256_key_exp u_key_exp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (exp_start),
    .key_i    ({key_q[0], key_q[1], key_q[2], key_q[3]}),
    .rd_en_i  (rd_en),
    .rd_row_i (rd_row),
    .rd_key_o (rkey),
    .done_o   (exp_done)
  );

  aes256_round u_round (
    .state_i   (data_q),
    .rkey_i    (rkey),
    .decrypt_i (decrypt_q),
    .last_i    (rnd_q == aes256_pkg::RowW'(aes256_pkg::NumRounds)),
    .state_o   (round_out)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      aes256_pkg::StIdle: begin
        if (accept) begin
          state_d = expanded_q ? aes256_pkg::StLoad : aes256_pkg::StExpand;
        end
      end
      aes256_pkg::StExpand: begin
        if (exp_done) begin
          state_d = aes256_pkg::StLoad;
        end
      end
      aes256_pkg::StLoad:  state_d = aes256_pkg::StInit;
      aes256_pkg::StInit:  state_d = aes256_pkg::StRound;
      aes256_pkg::StRound: begin
        if (rnd_q == aes256_pkg::RowW'(aes256_pkg::NumRounds)) begin
          state_d = aes256_pkg::StDone;
        end
      end
      aes256_pkg::StDone: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = aes256_pkg::StIdle;
        end
      end
      default: state_d = aes256_pkg::StIdle;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    exp_start  = 1'b0;
    rd_en      = 1'b0;
    rnd_next   = rnd_q + aes256_pkg::RowW'(1);
    out_load   = 1'b0;
    unique case (state_q)
      aes256_pkg::StIdle: begin
        in_ready_o = 1'b1;
        exp_start  = accept && !expanded_q;
      end
      aes256_pkg::StLoad: begin
        rd_en    = 1'b1;
        rnd_next = '0;
      end
      aes256_pkg::StInit: begin
        rd_en    = 1'b1;
        rnd_next = aes256_pkg::RowW'(1);
      end
      aes256_pkg::StRound: begin
        rd_en = rnd_q != aes256_pkg::RowW'(aes256_pkg::NumRounds);
      end
      aes256_pkg::StDone: begin
        out_load = !out_valid_q || out_ready_i;
      end
      default: ;
    endcase
    rd_row = decrypt_q ? aes256_pkg::RowW'(aes256_pkg::NumRounds) - rnd_next : rnd_next;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= aes256_pkg::StIdle;
      expanded_q  <= 1'b0;
      out_valid_q <= 1'b0;
      rnd_q       <= '0;
      for (int i = 0; i < aes256_pkg::KeyRegs; i++) begin
        key_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (aes256_pkg::cfg_idx_e'(cfg_index_i))
          aes256_pkg::CfgKey0: key_q[0] <= cfg_data_i;
          aes256_pkg::CfgKey1: key_q[1] <= cfg_data_i;
          aes256_pkg::CfgKey2: key_q[2] <= cfg_data_i;
          default:             key_q[3] <= cfg_data_i;
        endcase
        expanded_q <= 1'b0;
      end else if (exp_done) begin
        expanded_q <= 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == aes256_pkg::StInit || state_q == aes256_pkg::StRound) begin
        rnd_q <= rnd_next;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      data_q    <= {block_high_i, block_low_i};
      decrypt_q <= func_i;
    end else if (state_q == aes256_pkg::StInit) begin
      data_q <= data_q ^ rkey;
    end else if (state_q == aes256_pkg::StRound) begin
      data_q <= round_out;
    end
    if (out_load) begin
      result_q <= data_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign result_high_o = result_q[127:64];
  assign result_low_o  = result_q[63:0];

endmodule

`default_nettype wire

>>> sv/aes256_chk.sv
// Port-level checker for the AES-256 core, bound to the top level.
// Depends only on the ports of aes256_block_cipher_core.
`default_nettype none

module aes256_chk (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_o,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [63:0] result_high_o,
  input wire logic [63:0] result_low_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(result_high_o) &&
    $stable(result_low_o))
    else $error("result changed while stalled");

  a_busy_after_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request taken while busy");

  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !$rose(out_valid_o) ##1 !$rose(out_valid_o))
    else $error("result appeared too early");

endmodule

bind aes256_block_cipher_core aes256_chk u_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .result_high_o (result_high_o),
  .result_low_o  (result_low_o)
);

`default_nettype wire

>>> tb/aes256_block_cipher_core_tb.sv
// Testbench for the AES-256 ECB core: directed and random requests checked
// against a behavioural AES-256 predictor. Depends on aes256_pkg and the core.
`timescale 1ns / 100ps

module aes256_block_cipher_core_tb;

  typedef struct packed {
    logic        func;
    logic [63:0] hi;
    logic [63:0] lo;
  } blk_req_t;

  typedef struct packed {
    logic [63:0] hi;
    logic [63:0] lo;
  } blk_res_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_index_i;
  logic [63:0] cfg_data_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic        func_i;
  logic [63:0] block_high_i;
  logic [63:0] block_low_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [63:0] result_high_o;
  logic [63:0] result_low_o;

  aes256_block_cipher_core u_top (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_ready_o, .func_i, .block_high_i, .block_low_i,
    .out_valid_o, .out_ready_i, .result_high_o, .result_low_o
  );

  logic [7:0]  sbox [256];
  logic [7:0]  rev_sbox [256];
  logic [63:0] key_regs [4];
  logic [31:0] sched [60];
  bit          sched_valid;

  blk_req_t pending_q[$];
  blk_res_t cipher_q[$];
  int       err_cnt;
  int       sent_cnt;
  int       recv_cnt;
  int       enc_cnt;
  int       dec_cnt;
  int       burst_left;
  int       gap_left;
  int       hold_cycles;
  bit       long_hold;
  int       stall_phase;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #2000000;
    $display("aes256_block_cipher_core_tb NOT OK");
    $finish;
  end

  function automatic logic [7:0] gf_mul(logic [7:0] a, logic [7:0] b);
    logic [7:0] acc;
    acc = 8'h00;
    for (int k = 0; k < 8; k++) begin
      if (b[0]) acc = acc ^ a;
      a = a[7] ? ({a[6:0], 1'b0} ^ 8'h1b) : {a[6:0], 1'b0};
      b = b >> 1;
    end
    return acc;
  endfunction

  function automatic logic [31:0] sbox_word(logic [31:0] w);
    return {sbox[w[31:24]], sbox[w[23:16]], sbox[w[15:8]], sbox[w[7:0]]};
  endfunction

  task automatic build_schedule();
    logic [31:0] t;
    logic [7:0]  rc;
    for (int i = 0; i < 4; i++) begin
      sched[2*i]   = key_regs[i][63:32];
      sched[2*i+1] = key_regs[i][31:0];
    end
    rc = 8'h01;
    for (int i = 8; i < 60; i++) begin
      t = sched[i-1];
      if (i % 8 == 0) begin
        t = sbox_word({t[23:0], t[31:24]}) ^ {rc, 24'h0};
        rc = gf_mul(rc, 8'h02);
      end else if (i % 8 == 4) begin
        t = sbox_word(t);
      end
      sched[i] = sched[i-8] ^ t;
    end
    sched_valid = 1'b1;
  endtask

  function automatic void xor_round_key(ref logic [7:0] s[16], input int rnd);
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        s[c*4+r] ^= sched[rnd*4+c][31-8*r -: 8];
  endfunction

  function automatic void mix_cols(ref logic [7:0] s[16], input logic [7:0] m[4]);
    logic [7:0] t[16];
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        t[c*4+r] = gf_mul(m[(4-r)&3], s[c*4]) ^ gf_mul(m[(5-r)&3], s[c*4+1]) ^
                   gf_mul(m[(6-r)&3], s[c*4+2]) ^ gf_mul(m[(7-r)&3], s[c*4+3]);
    s = t;
  endfunction

  function automatic void sub_shift_rows(ref logic [7:0] s[16], input bit inv);
    logic [7:0] t[16];
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        if (inv) t[((c+r)&3)*4+r] = rev_sbox[s[c*4+r]];
        else     t[c*4+r] = sbox[s[((c+r)&3)*4+r]];
    s = t;
  endfunction

  task automatic predict_block(input blk_req_t rq);
    logic [7:0] s[16];
    logic [7:0] fwd_m[4];
    logic [7:0] inv_m[4];
    blk_res_t   res;
    fwd_m = '{8'h02, 8'h03, 8'h01, 8'h01};
    inv_m = '{8'h0e, 8'h0b, 8'h0d, 8'h09};
    if (!sched_valid) build_schedule();
    for (int i = 0; i < 8; i++) begin
      s[i]   = rq.hi[63-8*i -: 8];
      s[8+i] = rq.lo[63-8*i -: 8];
    end
    if (!rq.func) begin
      xor_round_key(s, 0);
      for (int rnd = 1; rnd < 14; rnd++) begin
        sub_shift_rows(s, 1'b0);
        mix_cols(s, fwd_m);
        xor_round_key(s, rnd);
      end
      sub_shift_rows(s, 1'b0);
      xor_round_key(s, 14);
      enc_cnt++;
    end else begin
      xor_round_key(s, 14);
      for (int rnd = 13; rnd > 0; rnd--) begin
        sub_shift_rows(s, 1'b1);
        xor_round_key(s, rnd);
        mix_cols(s, inv_m);
      end
      sub_shift_rows(s, 1'b1);
      xor_round_key(s, 0);
      dec_cnt++;
    end
    for (int i = 0; i < 8; i++) begin
      res.hi[63-8*i -: 8] = s[i];
      res.lo[63-8*i -: 8] = s[8+i];
    end
    cipher_q.push_back(res);
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("MISMATCH %s: got %h expected %h", what, got, want);
    err_cnt++;
  endtask

  // Driver: bursts of requests with random gaps between them.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i   <= 1'b0;
      func_i       <= 1'b0;
      block_high_i <= '0;
      block_low_i  <= '0;
      burst_left   <= 0;
      gap_left     <= 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        predict_block(pending_q.pop_front());
        sent_cnt++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (gap_left > 0) begin
          gap_left   <= gap_left - 1;
          in_valid_i <= 1'b0;
        end else if (pending_q.size() > 0) begin
          in_valid_i   <= 1'b1;
          func_i       <= pending_q[0].func;
          block_high_i <= pending_q[0].hi;
          block_low_i  <= pending_q[0].lo;
          if (burst_left > 0) begin
            burst_left <= burst_left - 1;
          end else begin
            burst_left <= $urandom_range(0, 6);
            gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold, counted here once it has been requested.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_cycles <= 0;
    end else if (long_hold && hold_cycles < 600) begin
      hold_cycles <= hold_cycles + 1;
    end
  end

  // Monitor and receiver stall pattern.
  always @(posedge clk_i or negedge rst_ni) begin
    blk_res_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      stall_phase <= 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        recv_cnt++;
        if (cipher_q.size() == 0) begin
          report_mismatch("unexpected result", result_high_o, '0);
        end else begin
          want = cipher_q.pop_front();
          if (result_high_o !== want.hi) report_mismatch("result_high", result_high_o, want.hi);
          if (result_low_o !== want.lo) report_mismatch("result_low", result_low_o, want.lo);
        end
      end
      if (long_hold && hold_cycles < 600) begin
        out_ready_i <= 1'b0;
      end else begin
        stall_phase <= (stall_phase + 1) % 97;
        if (stall_phase < 40) out_ready_i <= 1'b1;
        else out_ready_i <= ($urandom_range(0, 3) != 0);
      end
    end
  end

  task automatic write_key(input aes256_pkg::cfg_idx_e idx, input logic [63:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    key_regs[idx] = val;
    sched_valid = 1'b0;
  endtask

  task automatic drain();
    while (pending_q.size() > 0 || in_valid_i || cipher_q.size() > 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic push_req(input logic f, input logic [63:0] h, input logic [63:0] l);
    blk_req_t rq;
    rq.func = f;
    rq.hi   = h;
    rq.lo   = l;
    pending_q.push_back(rq);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  initial begin
    for (int i = 0; i < 256; i++) begin
      sbox[i] = aes256_pkg::FwdBox[i];
    end
    for (int i = 0; i < 256; i++) rev_sbox[sbox[i]] = i[7:0];
    for (int i = 0; i < 4; i++) key_regs[i] = '0;
    sched_valid = 1'b0;
    err_cnt = 0;
    sent_cnt = 0;
    recv_cnt = 0;
    enc_cnt = 0;
    dec_cnt = 0;
    long_hold = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = aes256_pkg::CfgKey0;
    cfg_data_i = '0;
    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // All-zero reset key, then field extremes.
    push_req(1'b0, '0, '0);
    push_req(1'b1, '0, '0);
    push_req(1'b0, '1, '1);
    push_req(1'b1, '1, '1);
    push_req(1'b0, 64'h8000000000000000, 64'h0000000000000001);
    drain();

    // The standard test vector key.
    write_key(aes256_pkg::CfgKey0, 64'h0001020304050607);
    write_key(aes256_pkg::CfgKey1, 64'h08090a0b0c0d0e0f);
    write_key(aes256_pkg::CfgKey2, 64'h1011121314151617);
    write_key(aes256_pkg::CfgKey3, 64'h18191a1b1c1d1e1f);
    push_req(1'b0, 64'h0011223344556677, 64'h8899aabbccddeeff);
    push_req(1'b1, 64'h8ea2b7ca516745bf, 64'heafc49904b496089);
    push_req(1'b0, 64'haaaaaaaaaaaaaaaa, 64'h5555555555555555);
    push_req(1'b1, 64'h5555555555555555, 64'haaaaaaaaaaaaaaaa);
    drain();

    // All-ones key, and a single-register change.
    for (int i = 0; i < 4; i++) write_key(aes256_pkg::cfg_idx_e'(i), '1);
    push_req(1'b0, '0, '1);
    push_req(1'b1, '1, '0);
    drain();
    write_key(aes256_pkg::CfgKey2, 64'h0123456789abcdef);
    push_req(1'b0, 64'h1, 64'h2);
    push_req(1'b1, 64'h3, 64'h4);

    // Long receiver hold while the sender keeps offering requests.
    long_hold = 1'b1;
    for (int i = 0; i < 30; i++) push_req(1'($urandom_range(0, 1)), rand64(), rand64());
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      if (ph % 2 == 0) begin
        for (int i = 0; i < 4; i++) write_key(aes256_pkg::cfg_idx_e'(i), rand64());
      end else begin
        write_key(aes256_pkg::cfg_idx_e'($urandom_range(0, 3)), rand64());
      end
      for (int i = 0; i < 230; i++) push_req(1'($urandom_range(0, 1)), rand64(), rand64());
      drain();
    end

    $display("Covered %0d requests (%0d encrypt, %0d decrypt), %0d results checked,",
             sent_cnt, enc_cnt, dec_cnt, recv_cnt);
    $display("over reset, standard, all-ones and random keys with receiver back-pressure.");
    if (err_cnt == 0) begin
      $display("aes256_block_cipher_core_tb OK");
    end else begin
      $display("aes256_block_cipher_core_tb NOT OK");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/aes256_pkg.sv
sv/aes256_key_exp.sv
sv/aes256_round.sv
sv/aes256_block_cipher_core.sv
sv/aes256_chk.sv
tb/aes256_block_cipher_core_tb.sv
